>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the odometry integrator RTL.
// No dependencies; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MOI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MOI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define MOI_ASSERT(lbl, clk, rst_n, prop)
`define MOI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/moi_pkg.sv
// Package for the mecanum odometry integrator: constants, micro-op codes,
// the datapath program and the controller/datapath command types. No dependencies.
`timescale 1ns / 1ps
package moi_pkg;

  localparam int HEADING_BITS_DEF = 16;

  localparam logic [15:0] WHEEL_RADIUS_RST = 16'd4997;
  localparam logic [15:0] INV_BASE_RST     = 16'd10240;

  typedef enum logic {
    REG_WHEEL_RADIUS = 1'b0,
    REG_INV_BASE     = 1'b1
  } reg_idx_t;

  localparam logic signed [31:0] C1_Q30 = 32'sd1686629713;
  localparam logic signed [31:0] C3_Q30 = 32'sd693598671;
  localparam logic signed [31:0] C5_Q30 = 32'sd85569278;
  localparam logic signed [31:0] C7_Q30 = 32'sd5026937;
  localparam logic signed [31:0] C9_Q30 = 32'sd172271;
  localparam logic [19:0] INV_PI_Q20 = 20'd333772;

  typedef enum logic [4:0] {
    MO_VX, MO_VY, MO_WR, MO_WZ,
    MO_SQ, MO_H7, MO_H5, MO_H3, MO_H1, MO_HX,
    MO_XC, MO_YS, MO_XS, MO_YC, MO_PH, MO_PL, MO_UP,
    MO_WT, MO_KH, MO_KL, MO_UH
  } mop_t;

  typedef struct packed {
    mop_t op;
    logic alt;
  } prog_t;

  localparam int PROG_LEN = 30;
  localparam int STEP_W   = $clog2(PROG_LEN);

  typedef struct packed {
    logic load;
    logic issue;
    logic wb;
    mop_t op;
    logic alt;
  } moi_cmd_t;

  typedef struct packed {
    logic dt_zero;
  } moi_stat_t;

  function automatic prog_t prog_at(logic [STEP_W-1:0] idx);
    prog_t p;
    p = '{op: MO_UH, alt: 1'b0};
    unique case (idx)
      5'd0:  p = '{op: MO_VX, alt: 1'b0};
      5'd1:  p = '{op: MO_VY, alt: 1'b0};
      5'd2:  p = '{op: MO_WR, alt: 1'b0};
      5'd3:  p = '{op: MO_WZ, alt: 1'b0};
      5'd4:  p = '{op: MO_SQ, alt: 1'b0};
      5'd5:  p = '{op: MO_H7, alt: 1'b0};
      5'd6:  p = '{op: MO_H5, alt: 1'b0};
      5'd7:  p = '{op: MO_H3, alt: 1'b0};
      5'd8:  p = '{op: MO_H1, alt: 1'b0};
      5'd9:  p = '{op: MO_HX, alt: 1'b0};
      5'd10: p = '{op: MO_SQ, alt: 1'b1};
      5'd11: p = '{op: MO_H7, alt: 1'b1};
      5'd12: p = '{op: MO_H5, alt: 1'b1};
      5'd13: p = '{op: MO_H3, alt: 1'b1};
      5'd14: p = '{op: MO_H1, alt: 1'b1};
      5'd15: p = '{op: MO_HX, alt: 1'b1};
      5'd16: p = '{op: MO_XC, alt: 1'b0};
      5'd17: p = '{op: MO_YS, alt: 1'b0};
      5'd18: p = '{op: MO_PH, alt: 1'b0};
      5'd19: p = '{op: MO_PL, alt: 1'b0};
      5'd20: p = '{op: MO_UP, alt: 1'b0};
      5'd21: p = '{op: MO_XS, alt: 1'b1};
      5'd22: p = '{op: MO_YC, alt: 1'b1};
      5'd23: p = '{op: MO_PH, alt: 1'b1};
      5'd24: p = '{op: MO_PL, alt: 1'b1};
      5'd25: p = '{op: MO_UP, alt: 1'b1};
      5'd26: p = '{op: MO_WT, alt: 1'b0};
      5'd27: p = '{op: MO_KH, alt: 1'b0};
      5'd28: p = '{op: MO_KL, alt: 1'b0};
      default: p = '{op: MO_UH, alt: 1'b0};
    endcase
    return p;
  endfunction

endpackage

>>> hw/rtl/moi_stream_if.sv
// Valid/ready channel interfaces for wheel speed requests and pose results.
// No dependencies.
`timescale 1ns / 1ps
interface moi_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_front_left;
  logic signed [15:0] speed_front_right;
  logic signed [15:0] speed_rear_left;
  logic signed [15:0] speed_rear_right;
  logic        [19:0] elapsed_time;

  modport source (output valid, speed_front_left, speed_front_right, speed_rear_left,
                  speed_rear_right, elapsed_time, input ready);
  modport sink (input valid, speed_front_left, speed_front_right, speed_rear_left,
                speed_rear_right, elapsed_time, output ready);
endinterface

interface moi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [15:0] pose_heading;
  logic signed [23:0] vel_x;
  logic signed [23:0] vel_y;
  logic signed [23:0] yaw_rate;

  modport source (output valid, pose_x, pose_y, pose_heading, vel_x, vel_y, yaw_rate,
                  input ready);
  modport sink (input valid, pose_x, pose_y, pose_heading, vel_x, vel_y, yaw_rate,
                output ready);
endinterface

>>> hw/rtl/mecanum_odometry_integrator.sv
// Top level of the mecanum wheel odometry integrator: register port,
// sequencer and datapath. Depends on moi_pkg, moi_stream_if, moi_ctrl and moi_dp.
`timescale 1ns / 1ps
// Usage:
// A request on in_chan carries four wheel speeds and the elapsed time. The block
// turns them into body velocity, rotates it by the stored heading and adds it to
// the stored position; the pose and velocity come out as one result on out_chan.
// A request with zero elapsed time is taken and dropped: no result, no update.
// One request is worked at a time. After acceptance the datapath runs a fixed
// program of 30 micro-ops on one shared registered multiplier, each issued and
// then written back; the result is valid after the last write-back, and the
// next request is taken the cycle after the result is taken. While the receiver
// stalls, the result holds and in_chan.ready stays low. Wheel radius (address 0)
// and inverse wheel base (address 4) are written and read over the APB-style
// port; the user must write them only while the block is idle; it does not check.
// Reset (rst_n low at a clock edge) clears position and heading and loads the
// default register values.
module mecanum_odometry_integrator
  import moi_pkg::*;
#(
  parameter int HEADING_BITS = HEADING_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  moi_in_if.sink      in_chan,
  moi_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] rim_radius_r;
  logic [15:0] inv_base_r;
  reg_idx_t    reg_idx;
  moi_cmd_t    cmd;
  moi_stat_t   stat;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rim_radius_r <= WHEEL_RADIUS_RST;
      inv_base_r   <= INV_BASE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_WHEEL_RADIUS: rim_radius_r <= pwdata[15:0];
        REG_INV_BASE:     inv_base_r   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WHEEL_RADIUS: prdata = {16'b0, rim_radius_r};
      REG_INV_BASE:     prdata = {16'b0, inv_base_r};
      default:          prdata = '0;
    endcase
  end

  moi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  moi_dp #(
    .HEADING_BITS (HEADING_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .rim_radius         (rim_radius_r),
    .inverse_wheel_base (inv_base_r),
    .speed_fl           (in_chan.speed_front_left),
    .speed_fr           (in_chan.speed_front_right),
    .speed_rl           (in_chan.speed_rear_left),
    .speed_rr           (in_chan.speed_rear_right),
    .elapsed_time       (in_chan.elapsed_time),
    .pose_x             (out_chan.pose_x),
    .pose_y             (out_chan.pose_y),
    .pose_heading       (out_chan.pose_heading),
    .vel_x              (out_chan.vel_x),
    .vel_y              (out_chan.vel_y),
    .yaw_rate           (out_chan.yaw_rate)
  );

endmodule

>>> hw/rtl/moi_ctrl.sv
// Sequencer for the odometry integrator: steps the datapath through its program.
// Depends on moi_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module moi_ctrl
  import moi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  moi_stat_t stat,
  output moi_cmd_t  cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROG_LEN - 1);

  state_t            state_r;
  logic [STEP_W-1:0] step_r;
  logic              phase_r;
  logic              out_valid_r;
  logic              in_fire;
  prog_t             cur;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign cur       = prog_at(step_r);

  always_comb begin
    cmd.load  = in_fire;
    cmd.issue = (state_r == ST_RUN) && !phase_r;
    cmd.wb    = (state_r == ST_RUN) && phase_r;
    cmd.op    = cur.op;
    cmd.alt   = cur.alt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && !stat.dt_zero) begin
            state_r <= ST_RUN;
            step_r  <= '0;
            phase_r <= 1'b0;
          end
        end
        ST_RUN: begin
          phase_r <= !phase_r;
          if (phase_r) begin
            if (step_r == LAST_STEP) begin
              state_r     <= ST_DONE;
              out_valid_r <= 1'b1;
            end else begin
              step_r <= step_r + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (out_ready) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b0;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `MOI_ASSERT(a_no_overlap, clk, rst_n, !(in_ready && out_valid_r))
  `MOI_ASSERT_IMP(a_done_after_last, clk, rst_n, $rose(out_valid_r), $past(cmd.wb && (step_r == LAST_STEP)))
  `MOI_ASSERT_IMP(a_step_bound, clk, rst_n, state_r == ST_RUN, step_r <= LAST_STEP)

endmodule

>>> hw/rtl/moi_dp.sv
// Datapath of the odometry integrator: one shared registered multiplier,
// working registers, sine polynomial and pose state. Depends on moi_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module moi_dp
  import moi_pkg::*;
#(
  parameter int HEADING_BITS = HEADING_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  moi_cmd_t           cmd,
  output moi_stat_t          stat,
  input  logic        [15:0] rim_radius,
  input  logic        [15:0] inverse_wheel_base,
  input  logic signed [15:0] speed_fl,
  input  logic signed [15:0] speed_fr,
  input  logic signed [15:0] speed_rl,
  input  logic signed [15:0] speed_rr,
  input  logic        [19:0] elapsed_time,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic signed [15:0] pose_heading,
  output logic signed [23:0] vel_x,
  output logic signed [23:0] vel_y,
  output logic signed [23:0] yaw_rate
);

  localparam int HSHIFT = 57 - HEADING_BITS;

  logic signed [17:0]             sx_r, sy_r, sz_r;
  logic        [19:0]             dt_r;
  logic signed [34:0]             t_r;
  logic signed [23:0]             vx_r, vy_r, wz_r;
  logic        [30:0]             x2_r;
  logic signed [31:0]             acc_r;
  logic        [16:0]             sa_r, sb_r;
  logic signed [42:0]             m1_r;
  logic signed [63:0]             big_r;
  logic signed [44:0]             q_r;
  logic signed [31:0]             pos_x_r, pos_y_r;
  logic        [HEADING_BITS-1:0] heading_r;
  logic signed [68:0]             prod_r;

  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic        [31:0] ph;
  logic        [16:0] px;
  logic signed [17:0] sin_v, cos_v;
  logic signed [38:0] hx;
  logic signed [27:0] wzt, dx;
  logic signed [32:0] pos_sum;
  logic signed [31:0] pos_sel;
  logic signed [63:0] dh;
  logic signed [32:0] dt_s, k_s, r_s, ib_s;

  assign stat.dt_zero = (elapsed_time == '0);

  assign ph   = {heading_r, {(32 - HEADING_BITS){1'b0}}};
  assign px   = cmd.alt ? (17'h10000 - {1'b0, ph[29:14]}) : {1'b0, ph[29:14]};
  assign dt_s = 33'($signed({1'b0, dt_r}));
  assign k_s  = 33'($signed({1'b0, INV_PI_Q20}));
  assign r_s  = 33'($signed({1'b0, rim_radius}));
  assign ib_s = 33'($signed({1'b0, inverse_wheel_base}));

  always_comb begin
    unique case (ph[31:30])
      2'd0: begin sin_v = $signed({1'b0, sa_r});  cos_v = $signed({1'b0, sb_r});  end
      2'd1: begin sin_v = $signed({1'b0, sb_r});  cos_v = -$signed({1'b0, sa_r}); end
      2'd2: begin sin_v = -$signed({1'b0, sa_r}); cos_v = -$signed({1'b0, sb_r}); end
      default: begin sin_v = -$signed({1'b0, sb_r}); cos_v = $signed({1'b0, sa_r}); end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      MO_VX: begin mul_a = 36'(sx_r); mul_b = r_s; end
      MO_VY: begin mul_a = 36'(sy_r); mul_b = r_s; end
      MO_WR: begin mul_a = 36'(sz_r); mul_b = r_s; end
      MO_WZ: begin mul_a = 36'(t_r);  mul_b = ib_s; end
      MO_SQ: begin
        mul_a = 36'($signed({1'b0, px}));
        mul_b = 33'($signed({1'b0, px}));
      end
      MO_H7, MO_H5, MO_H3, MO_H1: begin
        mul_a = 36'($signed({1'b0, x2_r}));
        mul_b = 33'(acc_r);
      end
      MO_HX: begin mul_a = 36'($signed({1'b0, px})); mul_b = 33'(acc_r); end
      MO_XC: begin mul_a = 36'(vx_r); mul_b = 33'(cos_v); end
      MO_YS: begin mul_a = 36'(vy_r); mul_b = 33'(sin_v); end
      MO_XS: begin mul_a = 36'(vx_r); mul_b = 33'(sin_v); end
      MO_YC: begin mul_a = 36'(vy_r); mul_b = 33'(cos_v); end
      MO_PH: begin mul_a = 36'(m1_r >>> 22); mul_b = dt_s; end
      MO_PL: begin mul_a = 36'($signed({1'b0, m1_r[21:0]})); mul_b = dt_s; end
      MO_WT: begin mul_a = 36'(wz_r); mul_b = dt_s; end
      MO_KH: begin mul_a = 36'(q_r >>> 22); mul_b = k_s; end
      MO_KL: begin mul_a = 36'($signed({1'b0, q_r[21:0]})); mul_b = k_s; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign hx      = 39'(prod_r >>> 30);
  assign wzt     = 28'(prod_r >>> 22);
  assign dx      = 28'(big_r >>> 36);
  assign pos_sel = cmd.alt ? pos_y_r : pos_x_r;
  assign pos_sum = 33'(pos_sel) + 33'(dx);
  assign dh      = big_r >>> HSHIFT;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r <= 18'(speed_fl) + 18'(speed_fr) + 18'(speed_rl) + 18'(speed_rr);
      sy_r <= -18'(speed_fl) + 18'(speed_fr) + 18'(speed_rl) - 18'(speed_rr);
      sz_r <= -18'(speed_fl) + 18'(speed_fr) - 18'(speed_rl) + 18'(speed_rr);
      dt_r <= elapsed_time;
    end
    if (cmd.issue) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.wb) begin
      unique case (cmd.op)
        MO_VX: vx_r <= 24'(prod_r >>> 10);
        MO_VY: vy_r <= 24'(prod_r >>> 10);
        MO_WR: t_r  <= 35'(prod_r);
        MO_WZ: begin
          if (wzt > 28'sd8388607) begin
            wz_r <= 24'sh7fffff;
          end else if (wzt < -28'sd8388608) begin
            wz_r <= 24'sh800000;
          end else begin
            wz_r <= 24'(wzt);
          end
        end
        MO_SQ: begin
          x2_r  <= prod_r[32:2];
          acc_r <= C9_Q30;
        end
        MO_H7: acc_r <= C7_Q30 - 32'(prod_r >>> 30);
        MO_H5: acc_r <= C5_Q30 - 32'(prod_r >>> 30);
        MO_H3: acc_r <= C3_Q30 - 32'(prod_r >>> 30);
        MO_H1: acc_r <= C1_Q30 - 32'(prod_r >>> 30);
        MO_HX: begin
          if (cmd.alt) begin
            sb_r <= (hx > 39'sd65536) ? 17'h10000 : hx[16:0];
          end else begin
            sa_r <= (hx > 39'sd65536) ? 17'h10000 : hx[16:0];
          end
        end
        MO_XC, MO_XS: m1_r <= 43'(prod_r);
        MO_YS: m1_r <= m1_r - 43'(prod_r);
        MO_YC: m1_r <= m1_r + 43'(prod_r);
        MO_PH, MO_KH: big_r <= 64'(prod_r <<< 22);
        MO_PL, MO_KL: big_r <= big_r + 64'(prod_r);
        MO_WT: q_r <= 45'(prod_r);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      heading_r <= '0;
    end else if (cmd.wb && (cmd.op == MO_UP)) begin
      if (pos_sum > 33'sd2147483647) begin
        if (cmd.alt) pos_y_r <= 32'sh7fffffff; else pos_x_r <= 32'sh7fffffff;
      end else if (pos_sum < -33'sd2147483648) begin
        if (cmd.alt) pos_y_r <= 32'sh80000000; else pos_x_r <= 32'sh80000000;
      end else begin
        if (cmd.alt) pos_y_r <= 32'(pos_sum); else pos_x_r <= 32'(pos_sum);
      end
    end else if (cmd.wb && (cmd.op == MO_UH)) begin
      heading_r <= heading_r + dh[HEADING_BITS-1:0];
    end
  end

  assign pose_x       = pos_x_r;
  assign pose_y       = pos_y_r;
  assign pose_heading = $signed(ph[31:16]);
  assign vel_x        = vx_r;
  assign vel_y        = vy_r;
  assign yaw_rate     = wz_r;

  `MOI_ASSERT(a_load_idle, clk, rst_n, !(cmd.load && (cmd.issue || cmd.wb)))
  `MOI_ASSERT_IMP(a_square_range, clk, rst_n, $past(cmd.wb && (cmd.op == MO_SQ)), x2_r <= 31'h40000000)

endmodule

>>> sim/mecanum_odometry_integrator_checker.sv
// Checker for the mecanum odometry integrator: watches the request, result and
// register ports, predicts each pose result and compares it field by field.
// Depends on moi_pkg for register indexes and the polynomial constants.
`timescale 1ns / 1ps
module mecanum_odometry_integrator_checker
  import moi_pkg::*;
#(
  parameter int HEADING_BITS = HEADING_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_fl,
  input  logic signed [15:0] in_fr,
  input  logic signed [15:0] in_rl,
  input  logic signed [15:0] in_rr,
  input  logic        [19:0] in_dt,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [15:0] out_heading,
  input  logic signed [23:0] out_vx,
  input  logic signed [23:0] out_vy,
  input  logic signed [23:0] out_wz,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] heading;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] wz;
  } pose_t;

  pose_t expected_poses[$];

  logic [15:0] radius;
  logic [15:0] inv_base;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [HEADING_BITS-1:0] heading;

  function automatic longint quarter_sine(longint x);
    longint x2;
    longint r;
    x2 = (x * x) >>> 2;
    r = C9_Q30;
    r = C7_Q30 - ((r * x2) >>> 30);
    r = C5_Q30 - ((r * x2) >>> 30);
    r = C3_Q30 - ((r * x2) >>> 30);
    r = C1_Q30 - ((r * x2) >>> 30);
    r = (r * x) >>> 30;
    return (r > 65536) ? 65536 : r;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void integrate_pose(input logic signed [15:0] fl, fr, rl, rr,
                                         input logic [19:0] dt, output pose_t p);
    longint vfl, vfr, vrl, vrr, vx, vy, wz, s, c, a, b, dx, dy, dh, t;
    logic [31:0] phase;
    logic [HEADING_BITS-1:0] h;
    vfl = longint'(fl) * longint'(radius);
    vfr = longint'(fr) * longint'(radius);
    vrl = longint'(rl) * longint'(radius);
    vrr = longint'(rr) * longint'(radius);
    vx = (vfl + vfr + vrl + vrr) >>> 10;
    vy = (-vfl + vfr + vrl - vrr) >>> 10;
    wz = sat(((-vfl + vfr - vrl + vrr) * longint'(inv_base)) >>> 22, -8388608, 8388607);
    phase = 32'(heading) << (32 - HEADING_BITS);
    a = quarter_sine(longint'(phase[29:14]));
    b = quarter_sine(65536 - longint'(phase[29:14]));
    case (phase[31:30])
      2'd0: begin s = a; c = b; end
      2'd1: begin s = b; c = -a; end
      2'd2: begin s = -a; c = -b; end
      default: begin s = -b; c = a; end
    endcase
    t = longint'(dt);
    dx = ((vx * c - vy * s) * t) >>> 36;
    dy = ((vx * s + vy * c) * t) >>> 36;
    pos_x = 32'(sat(longint'(pos_x) + dx, -64'sd2147483648, 64'sd2147483647));
    pos_y = 32'(sat(longint'(pos_y) + dy, -64'sd2147483648, 64'sd2147483647));
    dh = (wz * t * longint'(INV_PI_Q20)) >>> (57 - HEADING_BITS);
    h = heading + HEADING_BITS'(dh);
    heading = h;
    p.x = pos_x;
    p.y = pos_y;
    if (HEADING_BITS >= 16) p.heading = 16'(h >> (HEADING_BITS - 16));
    else p.heading = 16'(32'(h) << (16 - HEADING_BITS));
    p.vx = 24'(vx);
    p.vy = 24'(vy);
    p.wz = 24'(wz);
  endfunction

  always @(posedge clk) begin
    pose_t p;
    pose_t e;
    if (!rst_n) begin
      radius <= WHEEL_RADIUS_RST;
      inv_base <= INV_BASE_RST;
      pos_x <= '0;
      pos_y <= '0;
      heading <= '0;
      expected_poses.delete();
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_WHEEL_RADIUS: radius = pwdata[15:0];
          REG_INV_BASE:     inv_base = pwdata[15:0];
        endcase
      end
      if (in_valid && in_ready && in_dt != '0) begin
        integrate_pose(in_fl, in_fr, in_rl, in_rr, in_dt, p);
        expected_poses.push_back(p);
      end
      if (out_valid && out_ready) begin
        if (expected_poses.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) $display("Unexpected pose result x=%0d y=%0d", out_x, out_y);
        end else begin
          e = expected_poses.pop_front();
          if (out_x !== e.x || out_y !== e.y || out_heading !== e.heading ||
              out_vx !== e.vx || out_vy !== e.vy || out_wz !== e.wz) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display({"Pose mismatch: expected x=%0d y=%0d h=%0d vx=%0d vy=%0d wz=%0d,",
                        " got x=%0d y=%0d h=%0d vx=%0d vy=%0d wz=%0d"},
                       e.x, e.y, e.heading, e.vx, e.vy, e.wz,
                       out_x, out_y, out_heading, out_vx, out_vy, out_wz);
          end
        end
      end
      pending_count = expected_poses.size();
    end
  end

endmodule

>>> sim/mecanum_odometry_integrator_tb.sv
// Testbench top for the mecanum odometry integrator: drives wheel speed
// requests, register writes and result back-pressure, and gives the verdict.
// Depends on moi_pkg, moi_stream_if, the block and its checker.
`timescale 1ns / 1ps
module mecanum_odometry_integrator_tb;
  import moi_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count;
  int pending_count;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  moi_in_if in_if ();
  moi_out_if out_if ();

  initial begin
    in_if.valid = 1'b0;
    in_if.speed_front_left = '0;
    in_if.speed_front_right = '0;
    in_if.speed_rear_left = '0;
    in_if.speed_rear_right = '0;
    in_if.elapsed_time = '0;
    out_if.ready = 1'b0;
  end

  always #10 clk = ~clk;

  mecanum_odometry_integrator u_dut (
    .clk, .rst_n, .in_chan(in_if), .out_chan(out_if),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mecanum_odometry_integrator_checker u_checker (
    .clk, .rst_n,
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .in_fl(in_if.speed_front_left), .in_fr(in_if.speed_front_right),
    .in_rl(in_if.speed_rear_left), .in_rr(in_if.speed_rear_right),
    .in_dt(in_if.elapsed_time),
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .out_x(out_if.pose_x), .out_y(out_if.pose_y), .out_heading(out_if.pose_heading),
    .out_vx(out_if.vel_x), .out_vy(out_if.vel_y), .out_wz(out_if.yaw_rate),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending_count
  );

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_speeds(logic [15:0] fl, fr, rl, rr, logic [19:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.speed_front_left <= fl;
    in_if.speed_front_right <= fr;
    in_if.speed_rear_left <= rl;
    in_if.speed_rear_right <= rr;
    in_if.elapsed_time <= dt;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [15:0] rand_speed();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(512)) - 256);
      2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(8192)) - 4096);
    endcase
  endfunction

  function automatic logic [19:0] rand_dt();
    case ($urandom_range(9))
      0: return 20'd0;
      1: return 20'hFFFFF;
      2, 3: return 20'($urandom_range(2048, 1));
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic random_burst(int count);
    for (int i = 0; i < count; i++)
      send_speeds(rand_speed(), rand_speed(), rand_speed(), rand_speed(), rand_dt());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_speeds(16'h0100, 16'h0100, 16'h0100, 16'h0100, 20'd1024);
    send_speeds(16'h0100, 16'h0100, 16'h0100, 16'h0100, 20'd0);
    send_speeds(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 20'hFFFFF);
    send_speeds(16'h8000, 16'h8000, 16'h8000, 16'h8000, 20'hFFFFF);
    send_speeds(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 20'hFFFFF);
    send_speeds(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 20'hFFFFF);
    send_speeds(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 20'hFFFFF);
    send_speeds(16'h0000, 16'h0000, 16'h0000, 16'h0000, 20'd1);
    send_speeds(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 20'd1);
    for (int i = 0; i < 12; i++)
      send_speeds(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 20'hFFFFF);
    write_reg(REG_INV_BASE, 16'h0000);
    send_speeds(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 20'hFFFFF);

    send_idle_pct = 16;
    recv_idle_pct = 48;
    write_reg(REG_WHEEL_RADIUS, 16'hFFFF);
    write_reg(REG_INV_BASE, 16'hFFFF);
    random_burst(300);
    write_reg(REG_WHEEL_RADIUS, 16'h0000);
    write_reg(REG_INV_BASE, 16'h0001);
    random_burst(100);
    write_reg(REG_WHEEL_RADIUS, 16'($urandom));
    write_reg(REG_INV_BASE, 16'($urandom_range(65535, 1)));
    random_burst(200);

    send_idle_pct = 48;
    recv_idle_pct = 16;
    write_reg(REG_WHEEL_RADIUS, 16'h8000);
    write_reg(REG_INV_BASE, 16'h0400);
    random_burst(300);
    write_reg(REG_WHEEL_RADIUS, 16'd4997);
    write_reg(REG_INV_BASE, 16'd10240);
    random_burst(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_WHEEL_RADIUS, 16'($urandom));
    write_reg(REG_INV_BASE, 16'($urandom));
    random_burst(300);
    write_reg(REG_WHEEL_RADIUS, 16'hFFFF);
    write_reg(REG_INV_BASE, 16'hFFFF);
    random_burst(300);

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
